FILE: rtl/pssm_pkg.sv
// pssm_pkg: shared types, constants and helpers for the pairwise score
// similarity block. No dependencies; imported by every rtl module.
`default_nettype none

package pssm_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int IDX_IN_W = 6;
    localparam int SCORE_W  = 24;
    localparam int SIM_W    = 17;
    localparam int CNT_W    = 11;
    localparam int CFG_W    = 7;
    localparam int DIV_STEPS = 17;

    localparam logic [SIM_W-1:0] SIM_ONE   = 17'd65536;
    localparam logic [SIM_W-1:0] SIM_MAX   = 17'd131071;
    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

    localparam logic [CFG_W-1:0] ENTRIES_RST = 7'd64;
    localparam logic             REG_ENTRIES = 1'b0;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_COUNT = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_EVAL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic [SCORE_W-1:0] num;
        logic [SCORE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SIM_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic             valid;
        logic [SIM_W-1:0] sim;
        logic [CNT_W-1:0] pairs;
        logic             status;
    } t_result;

    function automatic logic [SCORE_W-1:0] umax(input logic [SCORE_W-1:0] a,
                                                input logic [SCORE_W-1:0] b);
        umax = (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pssm_store.sv
// pssm_store: square score memory, one shared read/write address,
// registered read data. Depends on pssm_pkg.
`default_nettype none

module pssm_store
    import pssm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [$clog2(MAX_ENTRIES*MAX_ENTRIES)-1:0] i_addr,
    input  wire logic [SCORE_W-1:0]                        i_wdata,
    output logic      [SCORE_W-1:0]                        o_rdata
);

    localparam int DEPTH = MAX_ENTRIES * MAX_ENTRIES;

    logic [SCORE_W-1:0] mem [DEPTH];
    logic [SCORE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/pssm_div.sv
// pssm_div: restoring divider for (num << 16) / den, one quotient bit per
// cycle, with zero-divisor and saturation shortcuts. Depends on pssm_pkg.
`default_nettype none

module pssm_div
    import pssm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic                r_busy;
    logic                r_first;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SCORE_W:0]    r_rem;
    logic [SIM_W-1:0]    r_q;
    // divisor held for the whole run
    logic [SCORE_W-1:0]  r_den_q;

    logic [SCORE_W:0]    w_trial;
    logic                w_ge;
    logic                w_short;

    assign w_trial = r_first ? r_rem : {r_rem[SCORE_W-1:0], 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_busy ? r_den_q : i_req.den});
    // zero divisor or a ratio of two or more needs no iterations
    assign w_short = (i_req.den == '0) || ({1'b0, i_req.num} >= {i_req.den, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= !w_short;
            r_done <= w_short;
        end else if (r_busy && r_step == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den_q <= i_req.den;
            r_rem   <= {1'b0, i_req.num};
            r_first <= 1'b1;
            r_step  <= STEP_W'(DIV_STEPS - 1);
            if (i_req.den == '0) begin
                r_q <= '0;
            end else begin
                // quotient at or above two saturates
                r_q <= SIM_MAX;
            end
        end else if (r_busy) begin
            r_rem   <= w_ge ? (w_trial - {1'b0, r_den_q}) : w_trial;
            r_q     <= {r_q[SIM_W-2:0], w_ge};
            r_first <= 1'b0;
            r_step  <= r_step - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

`default_nettype wire

FILE: rtl/pssm_seq.sv
// pssm_seq: request sequencer; drives the score memory, the shared max
// compare and the divider. Depends on pssm_pkg.
`default_nettype none

module pssm_seq
    import pssm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]          i_live,
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_ready,
    input  wire t_req                                      i_req,
    input  wire logic [IDX_IN_W-1:0]                       i_query,
    input  wire logic [IDX_IN_W-1:0]                       i_target,
    input  wire logic [SCORE_W-1:0]                        i_score,
    output logic                                           o_mem_we,
    output logic [$clog2(MAX_ENTRIES*MAX_ENTRIES)-1:0]     o_mem_addr,
    output logic [SCORE_W-1:0]                             o_mem_wdata,
    input  wire logic [SCORE_W-1:0]                        i_mem_rdata,
    output t_div_req                                       o_div,
    input  wire t_div_rsp                                  i_div,
    output t_result                                        o_res,
    input  wire logic                                      i_res_free
);

    localparam int DEPTH = MAX_ENTRIES * MAX_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int NW    = $clog2(MAX_ENTRIES + 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_sweep;
    logic               r_clr_req;
    logic               r_is_cnt;
    logic [IW-1:0]      r_a;
    logic [IW-1:0]      r_b;
    logic [SCORE_W-1:0] r_score;
    logic [SCORE_W-1:0] r_x;
    logic [SCORE_W-1:0] r_num;
    logic [SCORE_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic [SIM_W-1:0]   r_sim;
    logic               r_stat;

    logic               w_accept;
    logic               w_oor;
    logic               w_sweep_end;
    logic [NW:0]        w_b_inc;
    logic [NW:0]        w_a_inc2;
    logic               w_more_b;
    logic               w_more_a;
    logic [SCORE_W-1:0] w_max;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                                input logic [IW-1:0] col);
        cell_addr = AW'(row) * AW'(MAX_ENTRIES) + AW'(col);
    endfunction

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_oor       = (int'(i_query) >= int'(i_live)) || (int'(i_target) >= int'(i_live));
    assign w_sweep_end = (r_sweep == AW'(DEPTH - 1));
    assign w_b_inc     = (NW + 1)'(r_b) + (NW + 1)'(1);
    assign w_a_inc2    = (NW + 1)'(r_a) + (NW + 1)'(2);
    assign w_more_b    = (w_b_inc < (NW + 1)'(i_live));
    assign w_more_a    = (w_a_inc2 < (NW + 1)'(i_live));
    // shared max compare for the cross and self score pairs
    assign w_max       = umax(r_x, i_mem_rdata);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (w_sweep_end) begin
                    n_state = r_clr_req ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_req)
                        REQ_CLEAR: n_state = ST_SWEEP;
                        REQ_COUNT: n_state = (i_live < NW'(2)) ? ST_DONE : ST_RD0;
                        REQ_LOAD:  n_state = w_oor ? ST_DONE : ST_LD_RD;
                        REQ_READ: begin
                            if (w_oor || i_query == i_target) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_RD0;
                            end
                        end
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_LD_RD:    n_state = ST_LD_WR;
            ST_LD_WR:    n_state = ST_DONE;
            ST_RD0:      n_state = ST_RD1;
            ST_RD1:      n_state = ST_RD2;
            ST_RD2:      n_state = ST_RD3;
            ST_RD3:      n_state = ST_RD4;
            ST_RD4:      n_state = r_is_cnt ? ST_EVAL : ST_DIV_GO;
            ST_EVAL:     n_state = (w_more_b || w_more_a) ? ST_RD0 : ST_DONE;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: n_state = i_div.done ? ST_DONE : ST_DIV_WAIT;
            ST_DONE:     n_state = i_res_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = cell_addr(r_a, r_b);
        o_mem_wdata = r_score;
        o_div       = '0;
        o_res       = '0;
        case (r_state)
            ST_SWEEP: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_sweep;
                o_mem_wdata = '0;
            end
            ST_IDLE:   o_in_ready = 1'b1;
            ST_LD_WR:  o_mem_we   = (r_score > i_mem_rdata);
            ST_RD1:    o_mem_addr = cell_addr(r_b, r_a);
            ST_RD2:    o_mem_addr = cell_addr(r_a, r_a);
            ST_RD3:    o_mem_addr = cell_addr(r_b, r_b);
            ST_DIV_GO: begin
                o_div.start = 1'b1;
                o_div.num   = r_num;
                o_div.den   = r_den;
            end
            ST_DONE: begin
                o_res.valid  = 1'b1;
                o_res.sim    = r_sim;
                o_res.pairs  = r_cnt;
                o_res.status = r_stat;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_sweep   <= '0;
            r_clr_req <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (w_accept) begin
                r_sweep   <= '0;
                r_clr_req <= (i_req == REQ_CLEAR);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a      <= (i_req == REQ_COUNT) ? '0 : IW'(i_query);
            r_b      <= (i_req == REQ_COUNT) ? IW'(1) : IW'(i_target);
            r_score  <= i_score;
            r_is_cnt <= (i_req == REQ_COUNT);
            r_cnt    <= '0;
            r_stat   <= (i_req inside {REQ_LOAD, REQ_READ}) && w_oor;
            r_sim    <= (i_req == REQ_READ && !w_oor && i_query == i_target) ? SIM_ONE : '0;
        end
        case (r_state)
            ST_RD1: r_x   <= i_mem_rdata;
            ST_RD2: r_num <= w_max;
            ST_RD3: r_x   <= i_mem_rdata;
            ST_RD4: r_den <= w_max;
            ST_EVAL: begin
                if (r_den != '0 && r_num == r_den && r_cnt != COUNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_more_b) begin
                    r_b <= IW'(w_b_inc);
                end else begin
                    r_a <= r_a + 1'b1;
                    r_b <= IW'(w_a_inc2);
                end
            end
            ST_DIV_WAIT: begin
                if (i_div.done) begin
                    r_sim <= i_div.quo;
                end
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/pairwise_score_similarity_matrix_top.sv
// pairwise_score_similarity_matrix_top: stream ports, config register and
// result register around pssm_seq, pssm_store and pssm_div. Depends on pssm_pkg.
//
//   port group   dir  fields
//   s_axis       in   tuser: req_type; tdata: query, target, bit_score
//   m_axis       out  tuser: status; tdata: similarity, identical_pairs
//   apb          cfg  entries_in_use at byte address 0
//
// after reset the score memory is zeroed, one cell a cycle, before
// s_axis_tready rises. out-of-range load or read and diagonal read go straight
// to the result; a load writes the score only if it is larger than the stored
// one; other reads run 17 divider steps, skipped on a zero divisor or a ratio
// of two or more; count visits every pair r < c; clear zeroes every cell.
// read and count fetch four cells per pair through the single memory port, and
// read then runs the one-bit-per-cycle divider. a finished result waits in the
// output register while the next transfer is taken.
`default_nettype none

module pairwise_score_similarity_matrix_top
    import pssm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // query[5:0], target[11:6], bit_score[35:12]
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // similarity[16:0], identical_pairs[27:17]
    output logic [0:0]       m_axis_tuser,   // status[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(MAX_ENTRIES * MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);

    logic [CFG_W-1:0]   r_entries;
    logic [NW-1:0]      w_live;

    logic               w_mem_we;
    logic [AW-1:0]      w_mem_addr;
    logic [SCORE_W-1:0] w_mem_wdata;
    logic [SCORE_W-1:0] w_mem_rdata;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    t_result            w_res;
    logic               w_res_free;

    logic               r_out_valid;
    logic [SIM_W-1:0]   r_out_sim;
    logic [CNT_W-1:0]   r_out_pairs;
    logic               r_out_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRIES) begin
            r_entries <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ENTRIES) ? 32'(r_entries) : '0;

    assign w_live = (int'(r_entries) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(r_entries);

    pssm_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_live      (w_live),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (t_req'(s_axis_tuser)),
        .i_query     (s_axis_tdata[5:0]),
        .i_target    (s_axis_tdata[11:6]),
        .i_score     (s_axis_tdata[35:12]),
        .o_mem_we    (w_mem_we),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata),
        .o_div       (w_div_req),
        .i_div       (w_div_rsp),
        .o_res       (w_res),
        .i_res_free  (w_res_free)
    );

    pssm_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    pssm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // output register frees when empty or when its transfer completes
    assign w_res_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_res_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_res_free) begin
            r_out_sim   <= w_res.sim;
            r_out_pairs <= w_res.pairs;
            r_out_stat  <= w_res.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_pairs, r_out_sim};
    assign m_axis_tuser  = r_out_stat;

endmodule

`default_nettype wire
